>>> rtl/dmc_pkg.sv
// dmc_pkg: shared widths, status codes and control command type
// for the direct-mapped cache core; depends on nothing

package dmc_pkg;

	localparam int AddrW = 32;
	localparam int WordW = 32;
	localparam int TagW = 26;
	localparam int TagLsb = 6;
	localparam int SetFieldW = 4;
	localparam int SetLsb = 2;
	localparam int ByteW = 8;
	localparam int StatusW = 3;

	localparam logic [StatusW-1:0] ST_HIT = 3'd0;
	localparam logic [StatusW-1:0] ST_MISS_INVALID = 3'd1;
	localparam logic [StatusW-1:0] ST_MISS_TAG = 3'd2;
	localparam logic [StatusW-1:0] ST_FILL = 3'd3;
	localparam logic [StatusW-1:0] ST_EVICT = 3'd4;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

>>> rtl/direct_mapped_cache_16set_core.sv
// direct_mapped_cache_16set_core: top level of the direct-mapped cache
// depends on dmc_pkg, dmc_ctrl and dmc_datapath
//
// Direct-mapped cache of one 4-byte block per set. Address bits 1:0 pick the
// byte, bits 5:2 (modulo NUM_SETS) the set, bits 31:6 are the tag. A read
// returns the stored byte and hit / miss status; a write fills the set and
// reports any valid block it evicts. One item is in flight at a time: as it is
// accepted, the tag and data stores are read into registers; they are written
// in the lookup state together with the result registers, and the result is
// offered in the state after that, until it is taken. A new item is accepted in
// the cycle after the result is taken. Valid bits clear at reset; no clearing
// pass.

module direct_mapped_cache_16set_core #(
	parameter int NUM_SETS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [dmc_pkg::AddrW-1:0]            address,
	input  logic [dmc_pkg::WordW-1:0]            write_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dmc_pkg::StatusW-1:0]          status,
	output logic [dmc_pkg::SetFieldW-1:0]        set_index,
	output logic [dmc_pkg::TagW-1:0]             address_tag,
	output logic [dmc_pkg::TagW-1:0]             stored_tag,
	output logic [dmc_pkg::ByteW-1:0]            read_byte,
	output logic [dmc_pkg::WordW-1:0]            evicted_word
);

	dmc_pkg::cmd_t cmd;

	dmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dmc_datapath #(
		.NUM_SETS (NUM_SETS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.address      (address),
		.write_word   (write_word),
		.status       (status),
		.set_index    (set_index),
		.address_tag  (address_tag),
		.stored_tag   (stored_tag),
		.read_byte    (read_byte),
		.evicted_word (evicted_word)
	);

endmodule

>>> rtl/dmc_ctrl.sv
// dmc_ctrl: state machine sequencing one item through capture,
// lookup/update and result hand-off; depends on dmc_pkg

module dmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output dmc_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready = in_ready_q;
	assign out_valid = out_valid_q;
	assign cmd.capture = in_ready_q && in_valid;
	assign cmd.commit = (state_q == S_LOOK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_ready_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOOK;
						in_ready_q <= 1'b0;
					end
				end
				S_LOOK: begin
					state_q <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					in_ready_q <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

>>> rtl/dmc_datapath.sv
// dmc_datapath: set decode, valid bits, tag and data stores, result registers
// depends on dmc_pkg

module dmc_datapath #(
	parameter int NUM_SETS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dmc_pkg::cmd_t                        cmd,
	input  logic                                 kind,
	input  logic [dmc_pkg::AddrW-1:0]            address,
	input  logic [dmc_pkg::WordW-1:0]            write_word,
	output logic [dmc_pkg::StatusW-1:0]          status,
	output logic [dmc_pkg::SetFieldW-1:0]        set_index,
	output logic [dmc_pkg::TagW-1:0]             address_tag,
	output logic [dmc_pkg::TagW-1:0]             stored_tag,
	output logic [dmc_pkg::ByteW-1:0]            read_byte,
	output logic [dmc_pkg::WordW-1:0]            evicted_word
);

	localparam int Depth = (NUM_SETS < (1 << dmc_pkg::SetFieldW)) ?
		NUM_SETS : (1 << dmc_pkg::SetFieldW);
	localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int ModW = (($clog2(NUM_SETS + 1) > dmc_pkg::SetFieldW) ?
		$clog2(NUM_SETS + 1) : dmc_pkg::SetFieldW) + 1;

	logic [dmc_pkg::TagW-1:0]  tag_mem [Depth];
	logic [dmc_pkg::WordW-1:0] data_mem [Depth];
	logic [Depth-1:0]          valid_q;

	logic [ModW-1:0]               set_mod;
	logic [IdxW-1:0]               in_idx;

	logic                          kind_q;
	logic [1:0]                    off_q;
	logic [IdxW-1:0]               idx_q;
	logic [dmc_pkg::SetFieldW-1:0] set_q;
	logic [dmc_pkg::TagW-1:0]      tag_q;
	logic [dmc_pkg::WordW-1:0]     word_q;
	logic                          was_valid_q;
	logic [dmc_pkg::TagW-1:0]      rd_tag_q;
	logic [dmc_pkg::WordW-1:0]     rd_data_q;

	logic [dmc_pkg::StatusW-1:0]   status_q;
	logic [dmc_pkg::SetFieldW-1:0] set_index_q;
	logic [dmc_pkg::TagW-1:0]      address_tag_q;
	logic [dmc_pkg::TagW-1:0]      stored_tag_q;
	logic [dmc_pkg::ByteW-1:0]     read_byte_q;
	logic [dmc_pkg::WordW-1:0]     evicted_word_q;

	logic [dmc_pkg::ByteW-1:0]     sel_byte;

	// set field modulo set count, at most eight subtract steps on a 4-bit value
	always_comb begin
		set_mod = ModW'(address[dmc_pkg::SetLsb +: dmc_pkg::SetFieldW]);
		for (int i = 0; i < 8; i++) begin
			if (set_mod >= ModW'(NUM_SETS)) begin
				set_mod = set_mod - ModW'(NUM_SETS);
			end
		end
	end

	assign in_idx = set_mod[IdxW-1:0];

	always_comb begin
		case (off_q)
			2'd0: sel_byte = rd_data_q[7:0];
			2'd1: sel_byte = rd_data_q[15:8];
			2'd2: sel_byte = rd_data_q[23:16];
			2'd3: sel_byte = rd_data_q[31:24];
			default: sel_byte = rd_data_q[7:0];
		endcase
	end

	// capture item and registered store read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			off_q <= address[1:0];
			idx_q <= in_idx;
			set_q <= set_mod[dmc_pkg::SetFieldW-1:0];
			tag_q <= address[dmc_pkg::TagLsb +: dmc_pkg::TagW];
			word_q <= write_word;
			rd_tag_q <= tag_mem[in_idx];
			rd_data_q <= data_mem[in_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (kind_q == dmc_pkg::KIND_WRITE)) begin
			tag_mem[idx_q] <= tag_q;
			data_mem[idx_q] <= word_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			was_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				was_valid_q <= valid_q[in_idx];
			end
			if (cmd.commit && (kind_q == dmc_pkg::KIND_WRITE)) begin
				valid_q[idx_q] <= 1'b1;
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			set_index_q <= set_q;
			address_tag_q <= tag_q;
			stored_tag_q <= was_valid_q ? rd_tag_q : '0;
			if (kind_q == dmc_pkg::KIND_READ) begin
				read_byte_q <= was_valid_q ? sel_byte : '0;
				evicted_word_q <= '0;
				if (!was_valid_q) begin
					status_q <= dmc_pkg::ST_MISS_INVALID;
				end else if (rd_tag_q == tag_q) begin
					status_q <= dmc_pkg::ST_HIT;
				end else begin
					status_q <= dmc_pkg::ST_MISS_TAG;
				end
			end else begin
				read_byte_q <= '0;
				evicted_word_q <= was_valid_q ? rd_data_q : '0;
				status_q <= was_valid_q ? dmc_pkg::ST_EVICT : dmc_pkg::ST_FILL;
			end
		end
	end

	assign status = status_q;
	assign set_index = set_index_q;
	assign address_tag = address_tag_q;
	assign stored_tag = stored_tag_q;
	assign read_byte = read_byte_q;
	assign evicted_word = evicted_word_q;

endmodule
